@@ sv/assert_macros.svh @@
// Assertion macros shared by the triangle normal RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ sv/tfn_pkg.sv @@
// Shared types and fixed constants of the triangle normal pipeline.
// No dependencies.
`default_nettype none
package tfn_pkg;
  localparam int A_W     = 30;          // normalized magnitude width
  localparam int TGT_MSB = A_W - 1;     // leading one lands here
  localparam int SUM_W   = 2 * A_W + 2; // sum of three squares
  localparam int LEN_W   = A_W + 1;     // integer square root width

  typedef struct packed {
    logic vld;
    logic degen;
  } ctl_t;
endpackage
`default_nettype wire

@@ sv/tfn_cross.sv @@
// Edge vectors and exact cross product, three register stages.
// Depends on tfn_pkg.
`default_nettype none
module tfn_cross #(
  parameter int W = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire tfn_pkg::ctl_t       in_ctl,
  input  wire logic [12*W-1:0]     in_crd,
  output tfn_pkg::ctl_t            out_ctl,
  output logic signed [2*W+2:0]    xprod [3],
  output logic [3*(W+1)-1:0]       dvec
);
  localparam int DW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int CW = 2 * W + 3;

  tfn_pkg::ctl_t c1_r, c2_r, c3_r;
  logic signed [DW-1:0] u_r [3];
  logic signed [DW-1:0] v_r [3];
  logic signed [DW-1:0] d1_r [3];
  logic signed [DW-1:0] d2_r [3];
  logic signed [DW-1:0] d3_r [3];
  logic signed [PW-1:0] pa_r [3];
  logic signed [PW-1:0] pb_r [3];
  logic signed [CW-1:0] cr_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
    end else if (en) begin
      c1_r <= in_ctl;
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  genvar i;
  generate
    for (i = 0; i < 3; i++) begin : g_ax
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      logic signed [W-1:0] a_c, b_c, c_c, r_c;
      assign a_c = in_crd[i*W +: W];
      assign b_c = in_crd[(i+3)*W +: W];
      assign c_c = in_crd[(i+6)*W +: W];
      assign r_c = in_crd[(i+9)*W +: W];

      always_ff @(posedge clk) begin
        if (en) begin
          u_r[i]  <= DW'(b_c) - DW'(a_c);
          v_r[i]  <= DW'(c_c) - DW'(a_c);
          d1_r[i] <= DW'(a_c) - DW'(r_c);
          pa_r[i] <= u_r[J] * v_r[K];
          pb_r[i] <= u_r[K] * v_r[J];
          d2_r[i] <= d1_r[i];
          cr_r[i] <= CW'(pa_r[i]) - CW'(pb_r[i]);
          d3_r[i] <= d2_r[i];
        end
      end

      assign xprod[i] = cr_r[i];
      assign dvec[i*DW +: DW] = d3_r[i];
    end
  endgenerate

  assign out_ctl = c3_r;
endmodule
`default_nettype wire

@@ sv/tfn_norm.sv @@
// Magnitude, common scaling to a 30-bit range, sum of squares and a
// pipelined bit-pair integer square root. Depends on tfn_pkg.
`default_nettype none
module tfn_norm #(
  parameter int W = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire tfn_pkg::ctl_t                in_ctl,
  input  wire logic signed [2*W+2:0]        xprod [3],
  input  wire logic [3*(W+1)-1:0]           dist_in,
  output tfn_pkg::ctl_t                     out_ctl,
  output logic [3*tfn_pkg::A_W-1:0]         mag_out,
  output logic [2:0]                        neg_out,
  output logic [tfn_pkg::LEN_W-1:0]         len_out,
  output logic [3*(W+1)-1:0]                dist_out
);
  localparam int DW   = W + 1;
  localparam int CW   = 2 * W + 3;
  localparam int MW   = 2 * W + 2;
  localparam int AW   = tfn_pkg::A_W;
  localparam int SW   = tfn_pkg::SUM_W;
  localparam int LW   = tfn_pkg::LEN_W;
  localparam int PB_W = $clog2(MW);
  localparam int SH_W = $clog2(MW + AW);

  typedef struct packed {
    logic [2:0]      neg;
    logic [3*DW-1:0] d;
  } nd_t;

  // scaling stages
  tfn_pkg::ctl_t c4_r, c5_r, c6_r, c7_r;
  nd_t           s4_r, s5_r, s6_r, s7_r;
  logic [MW-1:0] mg4_r [3];
  logic [MW-1:0] mg5_r [3];
  logic [MW-1:0] or4_r;
  logic [SH_W-1:0] amt5_r;
  logic          rgt5_r;
  logic [AW-1:0] a6_r [3];
  logic [3*AW-1:0] a7_r;
  logic [2*AW-1:0] sq7_r [3];

  logic [MW-1:0]   mag_c [3];
  logic [PB_W-1:0] pos_c;
  logic            rgt_c;
  logic [SH_W-1:0] amt_c;

  // root stages, index 0 holds the sum
  tfn_pkg::ctl_t   qc_r [LW+1];
  nd_t             qs_r [LW+1];
  logic [3*AW-1:0] qa_r [LW+1];
  logic [SW-1:0]   rv_r [LW+1];
  logic [SW-1:0]   rt_r [LW+1];

  always_comb begin
    pos_c = '0;
    for (int b = 0; b < MW; b++) begin
      if (or4_r[b]) pos_c = PB_W'(b);
    end
    rgt_c = int'(pos_c) > tfn_pkg::TGT_MSB;
    if (rgt_c) amt_c = SH_W'(int'(pos_c) - tfn_pkg::TGT_MSB);
    else       amt_c = SH_W'(tfn_pkg::TGT_MSB - int'(pos_c));
  end

  genvar i, k;
  generate
    for (i = 0; i < 3; i++) begin : g_mag
      logic [MW+AW-1:0] wide_c, shl_c, shr_c;
      assign mag_c[i] = xprod[i][CW-1] ? MW'(-xprod[i]) : MW'(xprod[i]);
      assign wide_c   = (MW+AW)'(mg5_r[i]);
      assign shl_c    = wide_c << amt5_r;
      assign shr_c    = wide_c >> amt5_r;
      always_ff @(posedge clk) begin
        if (en) begin
          mg4_r[i] <= mag_c[i];
          mg5_r[i] <= mg4_r[i];
          a6_r[i]  <= rgt5_r ? shr_c[AW-1:0] : shl_c[AW-1:0];
          sq7_r[i] <= a6_r[i] * a6_r[i];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
      c7_r <= '0;
      qc_r[0] <= '0;
    end else if (en) begin
      c4_r       <= in_ctl;
      c5_r.vld   <= c4_r.vld;
      c5_r.degen <= (or4_r == '0);
      c6_r       <= c5_r;
      c7_r       <= c6_r;
      qc_r[0]    <= c7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r.neg <= {xprod[2][CW-1], xprod[1][CW-1], xprod[0][CW-1]};
      s4_r.d   <= dist_in;
      or4_r    <= mag_c[0] | mag_c[1] | mag_c[2];
      s5_r     <= s4_r;
      amt5_r   <= amt_c;
      rgt5_r   <= rgt_c;
      s6_r     <= s5_r;
      s7_r     <= s6_r;
      a7_r     <= {a6_r[2], a6_r[1], a6_r[0]};
      qs_r[0]  <= s7_r;
      qa_r[0]  <= a7_r;
      rv_r[0]  <= SW'(sq7_r[0]) + SW'(sq7_r[1]) + SW'(sq7_r[2]);
      rt_r[0]  <= '0;
    end
  end

  generate
    for (k = 1; k <= LW; k++) begin : g_root
      localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2*k);
      logic [SW-1:0] trial_c;
      logic          ge_c;
      assign trial_c = rt_r[k-1] + BIT;
      assign ge_c    = rv_r[k-1] >= trial_c;
      always_ff @(posedge clk) begin
        if (!rst_n) qc_r[k] <= '0;
        else if (en) qc_r[k] <= qc_r[k-1];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rv_r[k] <= ge_c ? rv_r[k-1] - trial_c : rv_r[k-1];
          rt_r[k] <= ge_c ? (rt_r[k-1] >> 1) + BIT : rt_r[k-1] >> 1;
          qs_r[k] <= qs_r[k-1];
          qa_r[k] <= qa_r[k-1];
        end
      end
    end
  endgenerate

  assign out_ctl  = qc_r[LW];
  assign mag_out  = qa_r[LW];
  assign neg_out  = qs_r[LW].neg;
  assign dist_out = qs_r[LW].d;
  assign len_out  = rt_r[LW][LW-1:0];
endmodule
`default_nettype wire

@@ sv/tfn_div.sv @@
// Restoring division of each magnitude by the length, one quotient bit per
// stage, then sign, orientation dot product and flip. Depends on tfn_pkg.
`default_nettype none
`include "assert_macros.svh"
module tfn_div #(
  parameter int W  = 24,
  parameter int NF = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      orient,
  input  wire tfn_pkg::ctl_t             in_ctl,
  input  wire logic [3*tfn_pkg::A_W-1:0] mag_in,
  input  wire logic [2:0]                neg_in,
  input  wire logic [tfn_pkg::LEN_W-1:0] len_in,
  input  wire logic [3*(W+1)-1:0]        dist_in,
  output tfn_pkg::ctl_t                  out_ctl,
  output logic signed [NF+1:0]           norm [3],
  output logic                           zero_dot
);
  localparam int DW  = W + 1;
  localparam int AW  = tfn_pkg::A_W;
  localparam int RW  = tfn_pkg::LEN_W;
  localparam int QW  = NF + 1;
  localparam int OW  = NF + 2;
  localparam int NW  = AW + NF + 1;
  localparam int PDW = DW + OW;
  localparam int SMW = PDW + 2;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << NF;

  tfn_pkg::ctl_t   c_r  [QW+1];
  logic [RW-1:0]   len_r [QW+1];
  logic [2:0]      ng_r [QW+1];
  logic [3*DW-1:0] d_r  [QW+1];
  logic [RW-1:0]   rem_r [QW+1][3];
  logic [QW-1:0]   num_r [QW+1][3];
  logic [QW-1:0]   q_r   [QW+1][3];

  tfn_pkg::ctl_t   cg_r, cp_r, cf_r;
  logic [3*DW-1:0] dg_r;
  logic signed [OW-1:0]  ng_g_r [3];
  logic signed [OW-1:0]  np_r [3];
  logic signed [PDW-1:0] prod_r [3];
  logic signed [OW-1:0]  nf_r [3];
  logic                  zd_r;

  logic signed [SMW-1:0] dot_c;
  logic                  flip_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r[0] <= '0;
      cg_r   <= '0;
      cp_r   <= '0;
      cf_r   <= '0;
    end else if (en) begin
      c_r[0] <= in_ctl;
      cg_r   <= c_r[QW];
      cp_r   <= cg_r;
      cf_r   <= cp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r[0] <= len_in;
      ng_r[0]  <= neg_in;
      d_r[0]   <= dist_in;
      dg_r     <= d_r[QW];
    end
  end

  genvar i, j;
  generate
    for (i = 0; i < 3; i++) begin : g_lane
      logic [NW-1:0] n_c;
      logic [QW-1:0] qc_c;
      logic signed [DW-1:0] dv_c;
      assign n_c  = (NW'(mag_in[i*AW +: AW]) << NF) + NW'(len_in >> 1);
      assign qc_c = (q_r[QW][i] > ONE_Q) ? ONE_Q : q_r[QW][i];
      assign dv_c = dg_r[i*DW +: DW];

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[0][i] <= RW'(n_c >> QW);
          num_r[0][i] <= n_c[QW-1:0];
          q_r[0][i]   <= '0;
          if (c_r[QW].degen)  ng_g_r[i] <= '0;
          else if (ng_r[QW][i]) ng_g_r[i] <= -OW'(qc_c);
          else                ng_g_r[i] <= OW'(qc_c);
          prod_r[i] <= dv_c * ng_g_r[i];
          np_r[i]   <= ng_g_r[i];
          nf_r[i]   <= flip_c ? -np_r[i] : np_r[i];
        end
      end

      for (j = 1; j <= QW; j++) begin : g_step
        logic [RW:0] trial_c, sub_c;
        logic        ge_c;
        assign trial_c = {rem_r[j-1][i], num_r[j-1][i][QW-1]};
        assign ge_c    = trial_c >= {1'b0, len_r[j-1]};
        assign sub_c   = trial_c - {1'b0, len_r[j-1]};
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[j][i] <= ge_c ? sub_c[RW-1:0] : trial_c[RW-1:0];
            num_r[j][i] <= num_r[j-1][i] << 1;
            q_r[j][i]   <= {q_r[j-1][i][QW-2:0], ge_c};
          end
        end
      end
      assign norm[i] = nf_r[i];
    end

    for (j = 1; j <= QW; j++) begin : g_side
      always_ff @(posedge clk) begin
        if (!rst_n) c_r[j] <= '0;
        else if (en) c_r[j] <= c_r[j-1];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          len_r[j] <= len_r[j-1];
          ng_r[j]  <= ng_r[j-1];
          d_r[j]   <= d_r[j-1];
        end
      end
    end
  endgenerate

  assign dot_c  = SMW'(prod_r[0]) + SMW'(prod_r[1]) + SMW'(prod_r[2]);
  assign flip_c = orient && dot_c[SMW-1];

  always_ff @(posedge clk) begin
    if (en) zd_r <= orient && (dot_c == '0);
  end

  assign out_ctl  = cf_r;
  assign zero_dot = zd_r;

  `ASSERT_IMPL(a_quot_bound, clk, rst_n, c_r[QW].vld && !c_r[QW].degen, (q_r[QW][0] <= ONE_Q) && (q_r[QW][1] <= ONE_Q) && (q_r[QW][2] <= ONE_Q))
endmodule
`default_nettype wire

@@ sv/triangle_face_normal.sv @@
// Triangle unit normal: edge cross product, normalization to Q1.16 and
// optional orientation against a reference point.
// Depends on tfn_pkg, tfn_cross, tfn_norm, tfn_div.
//
// Usage:
//  - Input channel in_*: one triangle per word, A, B, C and the reference
//    point, each coordinate COORD_WIDTH bits signed Q12.12.
//  - Output channel out_*: one word per triangle, in order: three normal
//    components (NORMAL_FRAC_BITS+2 bits, signed) and the zero_dot and
//    degenerate flags on out_tuser.
//  - cfg_wr_en/cfg_wr_data set orient mode; write only while idle.
//  - The 31-stage square root and the one-bit-per-stage divider lie between
//    accept and out_tvalid. Throughput: one word per cycle while in_tready
//    is high.
//  - Reset clears all valid bits, the output buffer and orient mode.
//  - A two-word output buffer takes results while the receiver stalls; the
//    whole pipeline holds (in_tready low) only once both entries are full.
//    Nothing is dropped or repeated across a stall.
`default_nettype none
`include "assert_macros.svh"
module triangle_face_normal #(
  parameter int COORD_WIDTH      = 24,
  parameter int NORMAL_FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // ax, ay, az, bx, by, bz, cx, cy, cz, ref_x, ref_y, ref_z
  input  wire logic [((12*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // norm_x, norm_y, norm_z
  output logic [((3*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0] out_tdata,
  // zero_dot, degenerate
  output logic [1:0] out_tuser
);
  localparam int W   = COORD_WIDTH;
  localparam int NF  = NORMAL_FRAC_BITS;
  localparam int DW  = W + 1;
  localparam int AW  = tfn_pkg::A_W;
  localparam int OW  = NF + 2;
  localparam int ODW = ((3*OW+7)/8)*8;
  localparam logic [1:0] BUF_EMPTY = 2'd0;
  localparam logic [1:0] BUF_ONE   = 2'd1;
  localparam logic [1:0] BUF_FULL  = 2'd2;
  localparam logic signed [OW-1:0] ONE_S = OW'(1) << NF;

  logic orient_r;
  logic en;
  tfn_pkg::ctl_t in_ctl, x_ctl, n_ctl, f_ctl;
  logic signed [2*W+2:0] xprod [3];
  logic [3*DW-1:0] x_dist, n_dist;
  logic [3*AW-1:0] n_mag;
  logic [2:0]      n_neg;
  logic [tfn_pkg::LEN_W-1:0] n_len;
  logic signed [OW-1:0] f_norm [3];
  logic f_zd;

  logic [1:0]     cnt_r, cnt_nxt;
  logic [ODW-1:0] hd_data_r, sk_data_r, new_data;
  logic [1:0]     hd_user_r, sk_user_r, new_user;
  logic push, pop, hd_new, hd_skid, sk_ld;
  logic signed [OW-1:0] ox_w, oy_w, oz_w;

  always_ff @(posedge clk) begin
    if (!rst_n) orient_r <= 1'b0;
    else if (cfg_wr_en) orient_r <= cfg_wr_data;
  end

  assign en        = (cnt_r != BUF_FULL);
  assign in_tready = en;
  // vld in the upper bit, degen below
  assign in_ctl    = {in_tvalid, 1'b0};

  tfn_cross #(.W(W)) u_cross (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_ctl(in_ctl), .in_crd(in_tdata[12*W-1:0]),
    .out_ctl(x_ctl), .xprod(xprod), .dvec(x_dist)
  );

  tfn_norm #(.W(W)) u_norm (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_ctl(x_ctl), .xprod(xprod), .dist_in(x_dist),
    .out_ctl(n_ctl), .mag_out(n_mag), .neg_out(n_neg),
    .len_out(n_len), .dist_out(n_dist)
  );

  tfn_div #(.W(W), .NF(NF)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .orient(orient_r),
    .in_ctl(n_ctl), .mag_in(n_mag), .neg_in(n_neg), .len_in(n_len),
    .dist_in(n_dist), .out_ctl(f_ctl), .norm(f_norm), .zero_dot(f_zd)
  );

  assign new_data = ODW'({f_norm[2], f_norm[1], f_norm[0]});
  assign new_user = {f_ctl.degen, f_zd};
  assign push     = en && f_ctl.vld;
  assign pop      = (cnt_r != BUF_EMPTY) && out_tready;

  always_comb begin
    cnt_nxt = cnt_r;
    hd_new  = 1'b0;
    hd_skid = 1'b0;
    sk_ld   = 1'b0;
    case (cnt_r)
      BUF_EMPTY: begin
        if (push) begin
          hd_new  = 1'b1;
          cnt_nxt = BUF_ONE;
        end
      end
      BUF_ONE: begin
        if (push && pop) hd_new = 1'b1;
        else if (pop) cnt_nxt = BUF_EMPTY;
        else if (push) begin
          sk_ld   = 1'b1;
          cnt_nxt = BUF_FULL;
        end
      end
      BUF_FULL: begin
        if (pop) begin
          hd_skid = 1'b1;
          cnt_nxt = BUF_ONE;
        end
      end
      default: cnt_nxt = BUF_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= BUF_EMPTY;
    else cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (hd_new) begin
      hd_data_r <= new_data;
      hd_user_r <= new_user;
    end else if (hd_skid) begin
      hd_data_r <= sk_data_r;
      hd_user_r <= sk_user_r;
    end
    if (sk_ld) begin
      sk_data_r <= new_data;
      sk_user_r <= new_user;
    end
  end

  assign out_tvalid = (cnt_r != BUF_EMPTY);
  assign out_tdata  = hd_data_r;
  assign out_tuser  = hd_user_r;

  assign ox_w = out_tdata[OW-1:0];
  assign oy_w = out_tdata[2*OW-1:OW];
  assign oz_w = out_tdata[3*OW-1:2*OW];

  `ASSERT_IMPL(a_degen_zero, clk, rst_n, out_tvalid && out_tuser[1], (ox_w == '0) && (oy_w == '0) && (oz_w == '0))
  `ASSERT_IMPL(a_norm_range, clk, rst_n, out_tvalid, (ox_w <= ONE_S) && (ox_w >= -ONE_S) && (oy_w <= ONE_S) && (oy_w >= -ONE_S) && (oz_w <= ONE_S) && (oz_w >= -ONE_S))
  `ASSERT_NEXT(a_full_drain, clk, rst_n, (cnt_r == BUF_FULL) && out_tready, cnt_r == BUF_ONE)
endmodule
`default_nettype wire
